FILE: rtl/etst_pkg.sv
// shared types, constants and codes for the event timing statistics table
package etst_pkg;

	localparam int NUM_ENTRIES_DEF = 32;
	localparam int ENTRY_W = 5;
	localparam int OP_W = 2;
	localparam int DATA_W = 32;
	localparam int HIST_DEPTH = 4;
	localparam logic [DATA_W-1:0] USEC_PER_SEC = 32'd1000000;
	localparam logic [DATA_W-1:0] TPS_RESET = 32'd1000000;

	localparam logic [OP_W-1:0] OP_START = 2'd0;
	localparam logic [OP_W-1:0] OP_FINISH = 2'd1;
	localparam logic [OP_W-1:0] OP_INCR = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic [ENTRY_W-1:0] entry;
		logic [DATA_W-1:0] timestamp;
	} in_item_t;

	typedef struct packed {
		logic [DATA_W-1:0] min_value;
		logic [DATA_W-1:0] max_value;
		logic [DATA_W-1:0] average;
		logic [DATA_W-1:0] event_count;
		logic updated;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic load;     // capture input item, start memory read
		logic prep;     // evaluate read data: elapsed time and window overrun
		logic div_start;
		logic commit;   // write back and form result
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_div;
		logic div_done;
	} dp_sts_t;

endpackage

FILE: rtl/etst_if.sv
// valid/ready channel interfaces carrying input and result items
interface etst_in_if;
	logic valid;
	logic ready;
	etst_pkg::in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface etst_out_if;
	logic valid;
	logic ready;
	etst_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/etst_div.sv
// restoring divider, one quotient bit per cycle
module etst_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);
	logic [31:0] quo_q;
	logic [31:0] rem_q;
	logic [31:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [32:0] trial;
	logic [32:0] shifted;

	assign shifted = {rem_q, quo_q[31]};
	assign trial = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
endmodule

FILE: rtl/etst_datapath.sv
// entry storage, statistics update and microsecond divide
module etst_datapath #(
	parameter int NUM_ENTRIES = etst_pkg::NUM_ENTRIES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [31:0]            cfg_wdata,
	input  etst_pkg::in_item_t     in_item,
	input  etst_pkg::dp_cmd_t      cmd,
	output etst_pkg::dp_sts_t      sts,
	output etst_pkg::out_item_t    res
);
	localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
	// one row per entry: min, max, avg, four history, window start, counter
	localparam int ROW_W = 9 * 32;

	logic [31:0] tps_q;
	logic [ROW_W-1:0] mem [NUM_ENTRIES];
	logic [NUM_ENTRIES-1:0] vld_q;
	logic [ROW_W-1:0] rd_q;
	logic rd_vld_q;
	etst_pkg::in_item_t item_q;
	logic in_range_q;
	logic [IDX_W-1:0] idx;
	logic [31:0] elapsed_q;
	logic over_q;
	logic [31:0] div_val;
	logic div_done;
	logic [31:0] tps_div;
	logic [52:0] prod;

	logic [31:0] r_min, r_max, r_avg, r_h0, r_h1, r_h2, r_h3, r_ws, r_cnt;
	logic [31:0] v, n_min, n_max, n_avg, n_ws, n_cnt;
	logic [127:0] n_hist;
	logic [33:0] sum;
	logic rec;

	assign idx = item_q.entry[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= etst_pkg::TPS_RESET;
		end else if (cfg_we) begin
			tps_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_item;
			in_range_q <= ({27'd0, in_item.entry} < 32'(NUM_ENTRIES));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rd_q <= mem[in_item.entry[IDX_W-1:0]];
		end
		if (cmd.commit && in_range_q) begin
			mem[idx] <= {n_min, n_max, n_avg, n_hist, n_ws, n_cnt};
		end
	end

	// untouched entries read as reset values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				rd_vld_q <= vld_q[in_item.entry[IDX_W-1:0]];
			end
			if (cmd.commit && in_range_q) begin
				vld_q[idx] <= 1'b1;
			end
		end
	end

	always_comb begin
		if (rd_vld_q) begin
			{r_min, r_max, r_avg, r_h0, r_h1, r_h2} = rd_q[ROW_W-1:96];
			r_h3 = rd_q[95:64];
			r_ws = rd_q[63:32];
			r_cnt = rd_q[31:0];
		end else begin
			r_min = '1;
			{r_max, r_avg, r_h0, r_h1, r_h2, r_h3, r_ws, r_cnt} = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			elapsed_q <= item_q.timestamp - r_ws;
			over_q <= (item_q.timestamp - r_ws) > tps_q;
		end
	end

	// tps/1e6 as (tps/64)/15625, reciprocal exact for 26-bit operands
	assign prod = {27'd0, tps_q[31:6]} * 53'd70368745; // 2^40/15625 rounded up
	assign tps_div = (tps_q < etst_pkg::USEC_PER_SEC) ? 32'd1 : {19'd0, prod[52:40]};

	assign sts.need_div = in_range_q && (item_q.op == etst_pkg::OP_FINISH);

	etst_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.div_start),
		.dividend(elapsed_q),
		.divisor(tps_div),
		.done(div_done),
		.quotient(div_val)
	);
	assign sts.div_done = div_done;

	always_comb begin
		rec = 1'b0;
		v = r_h0;
		n_ws = r_ws;
		n_cnt = r_cnt;
		case (item_q.op)
			etst_pkg::OP_START: n_ws = item_q.timestamp;
			etst_pkg::OP_FINISH: begin
				rec = 1'b1;
				v = div_val;
			end
			etst_pkg::OP_INCR: begin
				if (over_q) begin
					rec = 1'b1;
					v = r_cnt;
					n_ws = item_q.timestamp;
					n_cnt = 32'd1;
				end else begin
					n_cnt = r_cnt + 32'd1;
				end
			end
			default: ;
		endcase
		if (rec) begin
			n_min = (v < r_min) ? v : r_min;
			n_max = (v > r_max) ? v : r_max;
			sum = {2'b0, v} + {2'b0, r_h0} + {2'b0, r_h1} + {2'b0, r_h2};
			n_avg = sum[33:2];
			n_hist = {v, r_h0, r_h1, r_h2};
		end else begin
			v = r_h0;
			n_min = r_min;
			n_max = r_max;
			sum = '0;
			n_avg = r_avg;
			n_hist = {r_h0, r_h1, r_h2, r_h3};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (in_range_q) begin
				res <= '{n_min, n_max, n_avg, n_cnt, rec};
			end else begin
				res <= '0;
			end
		end
	end
endmodule

FILE: rtl/etst_ctrl.sv
// sequencer for read, evaluate, divide and write back of one item
module etst_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output etst_pkg::dp_cmd_t   cmd,
	input  etst_pkg::dp_sts_t   sts
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_READ = 3'd1;
	localparam logic [2:0] S_PREP = 3'd2;
	localparam logic [2:0] S_DIV = 3'd3;
	localparam logic [2:0] S_COMMIT = 3'd4;

	logic [2:0] state_q;
	logic out_valid_q;
	logic free;

	// result register frees as soon as it is taken
	assign free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.load = in_valid && in_ready;
		cmd.prep = (state_q == S_READ);
		cmd.div_start = (state_q == S_PREP) && sts.need_div;
		cmd.commit = (state_q == S_COMMIT) && free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_READ;
				S_READ: state_q <= S_PREP;
				S_PREP: state_q <= sts.need_div ? S_DIV : S_COMMIT;
				S_DIV: if (sts.div_done) state_q <= S_COMMIT;
				S_COMMIT: begin
					if (free) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: rtl/event_timing_statistics_table.sv
// top level of the event timing statistics table
//  channel | dir | handshake     | payload
//  in_ch   | in  | valid/ready   | op, entry, timestamp
//  out_ch  | out | valid/ready   | min_value, max_value, average, event_count, updated
//  cfg     | in  | cfg_we        | ticks_per_second
// an item steps through read, evaluate and write back; a finish also runs the bit-serial divider
// reset clears control state and the per-entry valid bits; no clearing pass
// a result waits in its output register; the next item is read meanwhile
module event_timing_statistics_table #(
	parameter int NUM_ENTRIES = etst_pkg::NUM_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	etst_in_if.sink     in_ch,
	etst_out_if.source  out_ch
);
	etst_pkg::dp_cmd_t cmd;
	etst_pkg::dp_sts_t sts;

	etst_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.cmd(cmd), .sts(sts)
	);

	etst_datapath #(.NUM_ENTRIES(NUM_ENTRIES)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_item(in_ch.data), .cmd(cmd), .sts(sts), .res(out_ch.data)
	);

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.prep, cmd.commit}))
		else $error("overlapping datapath commands");
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !cmd.load)
		else $error("load during commit");
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_ch.valid)
		else $error("commit without result");
endmodule

FILE: bench/tb_event_timing_statistics_table.sv
// testbench for the event timing statistics table: random and directed items checked against a predictor
module tb_event_timing_statistics_table;

	localparam logic [etst_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

	// expected results in order, with a running predictor of the table
	class stats_scoreboard;
		etst_pkg::out_item_t pending[$];
		logic [31:0] tps;
		logic [31:0] min_t[32];
		logic [31:0] max_t[32];
		logic [31:0] avg_t[32];
		logic [31:0] hist[32][4];
		logic [31:0] win_t[32];
		logic [31:0] cnt_t[32];
		int errors;
		int checked;
		int recorded;

		function new();
			tps = etst_pkg::TPS_RESET;
			errors = 0;
			checked = 0;
			recorded = 0;
			for (int i = 0; i < 32; i++) begin
				min_t[i] = '1;
				max_t[i] = '0;
				avg_t[i] = '0;
				win_t[i] = '0;
				cnt_t[i] = '0;
				for (int j = 0; j < 4; j++) hist[i][j] = '0;
			end
		endfunction

		function void record(int e, logic [31:0] v);
			logic [33:0] sum;
			if (v < min_t[e]) min_t[e] = v;
			if (v > max_t[e]) max_t[e] = v;
			hist[e][3] = hist[e][2];
			hist[e][2] = hist[e][1];
			hist[e][1] = hist[e][0];
			hist[e][0] = v;
			sum = 34'(hist[e][0]) + 34'(hist[e][1]) + 34'(hist[e][2]) + 34'(hist[e][3]);
			avg_t[e] = sum[33:2];
			recorded++;
		endfunction

		function void note_item(etst_pkg::in_item_t it);
			etst_pkg::out_item_t r;
			int e;
			logic [31:0] dv;
			logic [31:0] elapsed;
			e = it.entry;
			r.updated = 1'b0;
			elapsed = it.timestamp - win_t[e];
			case (it.op)
				etst_pkg::OP_START: win_t[e] = it.timestamp;
				etst_pkg::OP_FINISH: begin
					dv = tps / etst_pkg::USEC_PER_SEC;
					if (dv == 0) dv = 1;
					record(e, elapsed / dv);
					r.updated = 1'b1;
				end
				etst_pkg::OP_INCR: begin
					if (elapsed > tps) begin
						record(e, cnt_t[e]);
						cnt_t[e] = '0;
						win_t[e] = it.timestamp;
						r.updated = 1'b1;
					end
					cnt_t[e] = cnt_t[e] + 32'd1;
				end
				default: ;
			endcase
			r.min_value = min_t[e];
			r.max_value = max_t[e];
			r.average = avg_t[e];
			r.event_count = cnt_t[e];
			pending.push_back(r);
		endfunction

		function void check_result(etst_pkg::out_item_t got);
			etst_pkg::out_item_t x;
			checked++;
			if (pending.size() == 0) begin
				$error("result with nothing expected");
				errors++;
				return;
			end
			x = pending.pop_front();
			if (got.min_value !== x.min_value) begin
				$error("min_value exp %0d got %0d", x.min_value, got.min_value);
				errors++;
			end
			if (got.max_value !== x.max_value) begin
				$error("max_value exp %0d got %0d", x.max_value, got.max_value);
				errors++;
			end
			if (got.average !== x.average) begin
				$error("average exp %0d got %0d", x.average, got.average);
				errors++;
			end
			if (got.event_count !== x.event_count) begin
				$error("event_count exp %0d got %0d", x.event_count, got.event_count);
				errors++;
			end
			if (got.updated !== x.updated) begin
				$error("updated exp %0d got %0d", x.updated, got.updated);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;
	int send_idle = 0;
	int recv_idle = 0;
	int sent = 0;
	logic [31:0] now_ts = '0;
	stats_scoreboard sb;

	etst_in_if in_ch();
	etst_out_if out_ch();

	event_timing_statistics_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: random stalls, checks on accept
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
			out_ch.ready <= ($urandom_range(99) >= recv_idle);
		end else begin
			out_ch.ready <= 1'b0;
		end
	end

	// valid stays high after an accept; idling or draining drops it
	task automatic send_item(logic [1:0] op, logic [4:0] entry, logic [31:0] ts);
		while ($urandom_range(99) < send_idle) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= '{op: op, entry: entry, timestamp: ts};
		do @(posedge clk); while (!in_ch.ready);
		sb.note_item('{op: op, entry: entry, timestamp: ts});
		sent++;
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_tps(logic [31:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.tps = v;
	endtask

	// random phase: mostly start/incr/finish sequences on a moving clock
	task automatic random_items(int n);
		logic [4:0] e;
		int k;
		for (int i = 0; i < n; i++) begin
			e = 5'($urandom_range(31));
			k = $urandom_range(99);
			if (k < 5) begin
				send_item(2'($urandom_range(3)), e, $urandom());
			end else begin
				now_ts = now_ts + (k < 60 ? $urandom_range(3000) :
					(k < 85 ? $urandom_range(4000000) : $urandom()));
				if (k < 25) send_item(etst_pkg::OP_START, e, now_ts);
				else if (k < 45) send_item(etst_pkg::OP_FINISH, e, now_ts);
				else if (k < 97) send_item(etst_pkg::OP_INCR, e, now_ts);
				else send_item(OP_UNUSED, e, now_ts);
			end
		end
	endtask

	initial begin
		in_ch.valid <= 1'b0;
		in_ch.data <= '0;
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: field extremes, every op, divisor zero, wide average sum
		send_item(OP_UNUSED, 5'd0, 32'd0);
		send_item(etst_pkg::OP_FINISH, 5'd0, 32'hFFFF_FFFF);
		send_item(etst_pkg::OP_FINISH, 5'd0, 32'hFFFF_FFFE);
		send_item(etst_pkg::OP_START, 5'd31, 32'hFFFF_FFF0);
		send_item(etst_pkg::OP_FINISH, 5'd31, 32'h0000_0010);
		send_item(etst_pkg::OP_INCR, 5'd31, 32'h0000_0011);
		send_item(etst_pkg::OP_INCR, 5'd31, 32'h0020_0000);
		send_item(etst_pkg::OP_INCR, 5'd31, 32'h0020_0001);
		send_item(OP_UNUSED, 5'd31, 32'hFFFF_FFFF);
		write_tps(32'd0);
		send_item(etst_pkg::OP_START, 5'd1, 32'd0);
		send_item(etst_pkg::OP_FINISH, 5'd1, 32'hFFFF_FFFF);
		send_item(etst_pkg::OP_FINISH, 5'd1, 32'hFFFF_FFFF);
		send_item(etst_pkg::OP_FINISH, 5'd1, 32'hFFFF_FFFF);
		send_item(etst_pkg::OP_FINISH, 5'd1, 32'hFFFF_FFFF);
		send_item(etst_pkg::OP_INCR, 5'd1, 32'd1);
		send_item(etst_pkg::OP_INCR, 5'd1, 32'd1);
		write_tps(32'hFFFF_FFFF);
		send_item(etst_pkg::OP_FINISH, 5'd2, 32'hFFFF_FFFF);
		send_item(etst_pkg::OP_INCR, 5'd2, 32'hFFFF_FFFF);
		write_tps(32'd999_999);
		send_item(etst_pkg::OP_FINISH, 5'd2, 32'd12345);
		write_tps(etst_pkg::TPS_RESET);

		send_idle = 33; recv_idle = 51;
		random_items(400);
		drain();
		write_tps(32'd1);
		send_idle = 51; recv_idle = 33;
		random_items(400);
		// hold off until every result is back
		drain();
		write_tps(32'd3_000_000);
		send_idle = 0; recv_idle = 0;
		random_items(300);
		write_tps(32'd1000);
		random_items(200);
		drain();
		$display("sent %0d items, checked %0d results, %0d values recorded",
			sent, sb.checked, sb.recorded);
		$display("tick rates covered zero, one, 1000, 1e6, 3e6 and all ones");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
